// File: rtl/d2i_pkg.sv
// d2i_pkg: types and constants for the double to integer converter.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package d2i_pkg;
    localparam int FRAC_BITS = 52;
    localparam int EXP_BITS  = 11;
    localparam int DATA_W    = 64;

    typedef enum logic [1:0] {
        KIND_CEIL  = 2'd0,
        KIND_FLOOR = 2'd1,
        KIND_HALF  = 2'd2,
        KIND_TRUNC = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NAN  = 2'd1,
        ST_OVFL = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0] value_bits;
        logic [1:0]        kind;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] int_result;
        logic [1:0]               status;
    } out_word_t;
endpackage
`default_nettype wire

// File: rtl/d2i_if.sv
// d2i_if: valid/ready channel carrying one word.
// Depends on nothing; payload type is a parameter.
`timescale 1ns / 1ps
`default_nettype none
interface d2i_if #(parameter type word_t = logic) ();
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/d2i_core.sv
// d2i_core: combinational rounding and range check of one binary64 word.
// Depends on d2i_pkg.
`timescale 1ns / 1ps
`default_nettype none
module d2i_core #(
    parameter int INT_WIDTH = 64
) (
    input  wire d2i_pkg::in_word_t  in_word,
    output d2i_pkg::out_word_t      out_word
);
    import d2i_pkg::*;

    logic                 neg;
    logic [EXP_BITS-1:0]  ex;
    logic [FRAC_BITS:0]   sig;
    logic [DATA_W-1:0]    mag;
    logic [DATA_W:0]      mag_r;
    logic [DATA_W:0]      limit;
    logic [6:0]           rsh;
    logic [127:0]         wide;
    logic                 has_frac;
    logic                 half;
    logic                 inc;
    logic                 big;
    logic                 ok;

    always_comb
    begin
        neg  = in_word.value_bits[63];
        ex   = in_word.value_bits[62:52];
        sig  = {(ex != '0), in_word.value_bits[51:0]};
        big  = 1'b0;
        mag  = '0;
        has_frac = 1'b0;
        half = 1'b0;
        rsh  = '0;
        wide = '0;
        // integral case: exponent of lsb at or above zero
        if (ex >= 11'd1075)
        begin
            big = (ex > 11'd1086);
            mag = {11'd0, sig} << ex[3:0] - 4'd3;
            if (ex[3:0] < 4'd3)
                mag = {11'd0, sig} << (ex - 11'd1075);
        end
        else
        begin
            // shift right by r = 1075 - exp, subnormal uses exp 1
            if (ex == '0)
                rsh = 7'd74;
            else if (ex <= 11'd1011)
                rsh = 7'd64;
            else
                rsh = 7'(11'd1075 - ex);
            if (rsh >= 7'd64)
            begin
                has_frac = (sig != '0);
            end
            else
            begin
                wide = {11'd0, sig, 64'd0} >> rsh;
                mag  = wide[127:64];
                has_frac = (wide[63:0] != '0);
                half = wide[63];
            end
        end
        unique case (kind_t'(in_word.kind))
            KIND_CEIL:  inc = !neg && has_frac;
            KIND_FLOOR: inc = neg && has_frac;
            KIND_HALF:  inc = half;
            default:    inc = 1'b0;
        endcase
        mag_r = {1'b0, mag} + {{DATA_W{1'b0}}, inc};
        limit = {{DATA_W{1'b0}}, 1'b1} << (INT_WIDTH - 1);
        ok = !big && (neg ? (mag_r <= limit) : (mag_r < limit));
        if (ex == '1)
        begin
            out_word.int_result = '0;
            out_word.status = (in_word.value_bits[51:0] != '0) ? ST_NAN : ST_OVFL;
        end
        else if (!ok)
        begin
            out_word.int_result = '0;
            out_word.status = ST_OVFL;
        end
        else
        begin
            out_word.int_result = neg ? -mag_r[DATA_W-1:0] : mag_r[DATA_W-1:0];
            out_word.status = ST_OK;
        end
    end
endmodule
`default_nettype wire

// File: rtl/double_to_int_rounding_converter.sv
// Double to integer converter, one word per cycle while the output is not stalled.
// Each word passes through the input register, then the result register.
// Throughput: one word every cycle; a stalled result holds and backs up the input.
// Reset clears both valid flags; payload registers are not reset.
// Depends on d2i_pkg, d2i_if, d2i_core.
`timescale 1ns / 1ps
`default_nettype none
module double_to_int_rounding_converter #(
    parameter int INT_WIDTH = 64
) (
    input wire clk,
    input wire rst_n,
    d2i_if.sink   in_ch,
    d2i_if.source out_ch
);
    import d2i_pkg::*;

    in_word_t  in_reg;
    logic      in_vld_reg;
    out_word_t res_reg;
    logic      res_vld_reg;
    out_word_t res_next;
    logic      adv;

    // pipeline moves when result slot is free or being taken
    assign adv = !res_vld_reg || out_ch.ready;
    assign in_ch.ready = adv || !in_vld_reg;

    d2i_core #(.INT_WIDTH(INT_WIDTH)) u_core (
        .in_word (in_reg),
        .out_word(res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                res_vld_reg <= in_vld_reg;
            if (in_ch.ready)
                in_vld_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_vld_reg)
            res_reg <= res_next;
        if (in_ch.ready && in_ch.valid)
            in_reg <= in_ch.data;
    end

    assign out_ch.valid = res_vld_reg;
    assign out_ch.data  = res_reg;

`ifndef SYNTH
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.status != ST_OK |-> out_ch.data.int_result == '0)
        else $error("error word with nonzero result");
    a_no_rsvd: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.data.status != ST_RSVD)
        else $error("reserved status");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && !out_ch.ready |=> res_vld_reg && $stable(res_reg))
        else $error("result lost while stalled");
`endif
endmodule
`default_nettype wire
